[hdl/dmc_pkg.sv]
// shared types and constants of the direct-mapped read cache
package dmc_pkg;

   localparam int ADDR_W = 12;
   localparam int DATA_W = 8;
   localparam int CNT_W  = 16;
   localparam int TIME_W = 32;
   localparam int CFG_W  = 8;
   localparam int CSR_IDX_W = 1;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 72;

   localparam int NUM_LINES_DEF  = 8;
   localparam int LINE_BYTES_DEF = 16;
   localparam int MEM_BYTES_DEF  = 4096;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_HIT_TIME     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_PENALTY = 1'b1;

   localparam logic [CFG_W-1:0] HIT_TIME_RST     = 8'd1;
   localparam logic [CFG_W-1:0] MISS_PENALTY_RST = 8'd10;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic fill_step;
      logic line_rd;
      logic out_load;
   } dmc_cmd_type;

   typedef struct packed {
      logic is_read;
      logic hit;
      logic fill_done;
      logic out_free;
   } dmc_sts_type;

endpackage

[hdl/dmc_ctrl.sv]
// controller state machine of the direct-mapped read cache
module dmc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_kind,
   input  dmc_pkg::dmc_sts_type sts,
   output dmc_pkg::dmc_cmd_type cmd
);
   import dmc_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_FILL,
      S_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.capture = 1'b1;
               state_in    = (req_kind == REQ_READ) ? S_LOOKUP : S_RESPOND;
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            if (sts.hit) begin
               cmd.line_rd = 1'b1;
               state_in    = S_RESPOND;
            end else begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.fill_done) begin
               cmd.line_rd = 1'b1;
               state_in    = S_RESPOND;
            end
         end
         S_RESPOND: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

   a_ready_only_idle : assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE)
      else $error("ready raised outside idle");

   a_fill_holds : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL && !sts.fill_done) |=> state_ff == S_FILL)
      else $error("fill left before the line was complete");

endmodule

[hdl/dmc_dpath.sv]
// datapath of the direct-mapped read cache: memories, tags, counters, output register
module dmc_dpath #(
   parameter int NUM_LINES  = dmc_pkg::NUM_LINES_DEF,
   parameter int LINE_BYTES = dmc_pkg::LINE_BYTES_DEF,
   parameter int MEM_BYTES  = dmc_pkg::MEM_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dmc_pkg::dmc_cmd_type           cmd,
   output dmc_pkg::dmc_sts_type           sts,
   input  logic                           req_type,
   input  logic [dmc_pkg::ADDR_W-1:0]     req_address,
   input  logic [dmc_pkg::DATA_W-1:0]     req_write_data,
   input  logic                           csr_wen,
   input  logic [dmc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dmc_pkg::CFG_W-1:0]      csr_wdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic                           rsp_hit,
   output logic [dmc_pkg::DATA_W-1:0]     rsp_read_data,
   output logic [dmc_pkg::CNT_W-1:0]      rsp_miss_count,
   output logic [dmc_pkg::CNT_W-1:0]      rsp_access_count,
   output logic [dmc_pkg::TIME_W-1:0]     rsp_elapsed_time
);
   import dmc_pkg::*;

   localparam int WORD_W  = $clog2(LINE_BYTES);
   localparam int LINE_W  = $clog2(NUM_LINES);
   localparam int MEM_AW  = $clog2(MEM_BYTES);
   localparam int TAG_LSB = WORD_W + LINE_W;
   localparam int TAG_W   = (ADDR_W > TAG_LSB) ? ADDR_W - TAG_LSB : 1;

   // captured request
   logic              req_type_ff;
   logic [ADDR_W-1:0] addr_ff;

   // configuration
   logic [CFG_W-1:0] hit_time_ff, miss_penalty_ff;

   // memories and tags
   logic [DATA_W-1:0] backing_mem [MEM_BYTES];
   logic [DATA_W-1:0] line_mem [NUM_LINES*LINE_BYTES];
   logic [TAG_W-1:0]  tag_ff [NUM_LINES];
   logic              valid_ff [NUM_LINES];

   // fill sequencing
   logic [WORD_W:0]   fill_cnt_ff;
   logic              wr_v_ff;
   logic [WORD_W-1:0] wr_idx_ff;
   logic [DATA_W-1:0] mem_q_ff;
   logic [DATA_W-1:0] line_q_ff;
   logic              hit_ff;

   // statistics
   logic [CNT_W-1:0]  miss_ff, miss_in;
   logic [CNT_W-1:0]  access_ff, access_in;
   logic [TIME_W-1:0] time_ff, time_in;

   // output register
   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [CNT_W-1:0]  rsp_miss_ff, rsp_access_ff;
   logic [TIME_W-1:0] rsp_time_ff;

   logic [WORD_W-1:0] word_idx;
   logic [LINE_W-1:0] line_idx;
   logic [TAG_W-1:0]  tag_val;
   logic [ADDR_W-1:0] blk_addr;
   logic [MEM_AW-1:0] fill_addr;
   logic              lookup_hit;
   logic [CFG_W:0]    add_amt;
   logic [TIME_W:0]   time_sum;

   always_comb begin
      word_idx   = WORD_W'(addr_ff);
      line_idx   = LINE_W'(addr_ff >> WORD_W);
      tag_val    = TAG_W'(addr_ff >> TAG_LSB);
      blk_addr   = addr_ff >> WORD_W;
      fill_addr  = MEM_AW'({blk_addr, fill_cnt_ff[WORD_W-1:0]});
      lookup_hit = valid_ff[line_idx] && (tag_ff[line_idx] == tag_val);

      add_amt  = {1'b0, hit_time_ff} + (lookup_hit ? '0 : {1'b0, miss_penalty_ff});
      time_sum = {1'b0, time_ff} + (TIME_W+1)'(add_amt);
      time_in  = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];

      access_in = (access_ff == '1) ? access_ff : access_ff + 1'b1;
      miss_in   = (lookup_hit || miss_ff == '1) ? miss_ff : miss_ff + 1'b1;
   end

   assign sts.is_read   = (req_type_ff == REQ_READ);
   assign sts.hit       = lookup_hit;
   assign sts.fill_done = fill_cnt_ff[WORD_W] && !wr_v_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         addr_ff     <= req_address;
      end
      if (cmd.lookup) begin
         hit_ff <= lookup_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_time_ff     <= HIT_TIME_RST;
         miss_penalty_ff <= MISS_PENALTY_RST;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_HIT_TIME:     hit_time_ff     <= csr_wdata;
            CSR_MISS_PENALTY: miss_penalty_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // backing memory: loads write, fill reads one byte a cycle
   always_ff @(posedge clock) begin
      if (cmd.capture && req_type == REQ_LOAD) begin
         backing_mem[MEM_AW'(req_address)] <= req_write_data;
      end
      if (cmd.fill_step && !fill_cnt_ff[WORD_W]) begin
         mem_q_ff <= backing_mem[fill_addr];
      end
   end

   // line storage: each fill write lands in the cycle after its memory read
   always_ff @(posedge clock) begin
      if (wr_v_ff) begin
         line_mem[{line_idx, wr_idx_ff}] <= mem_q_ff;
      end
      if (cmd.line_rd) begin
         line_q_ff <= line_mem[{line_idx, word_idx}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup && !lookup_hit) begin
         tag_ff[line_idx] <= tag_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            valid_ff[i] <= 1'b0;
         end
         fill_cnt_ff <= '0;
         wr_v_ff     <= 1'b0;
         wr_idx_ff   <= '0;
         miss_ff     <= '0;
         access_ff   <= '0;
         time_ff     <= '0;
      end else begin
         wr_v_ff <= 1'b0;
         if (cmd.lookup) begin
            access_ff   <= access_in;
            miss_ff     <= miss_in;
            time_ff     <= time_in;
            fill_cnt_ff <= '0;
            if (!lookup_hit) begin
               valid_ff[line_idx] <= 1'b1;
            end
         end else if (cmd.fill_step && !fill_cnt_ff[WORD_W]) begin
            wr_v_ff     <= 1'b1;
            wr_idx_ff   <= fill_cnt_ff[WORD_W-1:0];
            fill_cnt_ff <= fill_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_hit_ff    <= sts.is_read ? hit_ff : 1'b0;
         rsp_data_ff   <= sts.is_read ? line_q_ff : '0;
         rsp_miss_ff   <= miss_ff;
         rsp_access_ff <= access_ff;
         rsp_time_ff   <= time_ff;
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_miss_count   = rsp_miss_ff;
   assign rsp_access_count = rsp_access_ff;
   assign rsp_elapsed_time = rsp_time_ff;

   a_line_present_after_lookup : assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |=> sts.hit)
      else $error("line not marked present after lookup");

   a_misses_within_accesses : assert property (@(posedge clock) disable iff (reset)
      miss_ff <= access_ff)
      else $error("miss count exceeds access count");

   a_fill_write_follows_step : assert property (@(posedge clock) disable iff (reset)
      wr_v_ff |-> $past(cmd.fill_step))
      else $error("line write without a fill step");

   a_access_monotonic : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> access_ff >= $past(access_ff))
      else $error("access count went backwards");

endmodule

[hdl/direct_mapped_cache_read.sv]
// top level of the direct-mapped read cache
//
//  channel   direction  handshake                fields (low bit up)
//  req_      in         req_tvalid/req_tready    tuser: req_type; tdata: address, write_data
//  rsp_      out        rsp_tvalid/rsp_tready    tuser: hit; tdata: read_data, miss_count,
//                                                access_count, elapsed_time
//  csr_      in         csr_wen                  csr_index, csr_wdata (no read-back)
//
// a load goes straight to the respond state, a read hit through lookup and a line read;
// a read miss puts a fill between lookup and line read that copies the line from backing
// memory one byte a cycle through its single read port.
// the next request is taken once the previous result sits in the output register.
// synchronous reset clears valid bits, counters and handshake state and presets the csr
// registers; memory is undefined until written. a stalled rsp_ side holds the block.
module direct_mapped_cache_read #(
   parameter int NUM_LINES  = dmc_pkg::NUM_LINES_DEF,
   parameter int LINE_BYTES = dmc_pkg::LINE_BYTES_DEF,
   parameter int MEM_BYTES  = dmc_pkg::MEM_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dmc_pkg::REQ_TDATA_W-1:0]    req_tdata,   // address, write_data, zero pad
   input  logic                               req_tuser,   // req_type
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dmc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // read_data, miss_count,
                                                           // access_count, elapsed_time
   output logic                               rsp_tuser,   // hit
   input  logic                               csr_wen,
   input  logic [dmc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dmc_pkg::CFG_W-1:0]          csr_wdata
);
   import dmc_pkg::*;

   dmc_cmd_type cmd;
   dmc_sts_type sts;

   logic [ADDR_W-1:0] req_address;
   logic [DATA_W-1:0] req_write_data;
   logic [DATA_W-1:0] rsp_read_data;
   logic [CNT_W-1:0]  rsp_miss_count, rsp_access_count;
   logic [TIME_W-1:0] rsp_elapsed_time;

   assign req_address    = req_tdata[ADDR_W-1:0];
   assign req_write_data = req_tdata[ADDR_W +: DATA_W];

   assign rsp_tdata = {rsp_elapsed_time, rsp_access_count, rsp_miss_count, rsp_read_data};

   dmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   dmc_dpath #(
      .NUM_LINES  (NUM_LINES),
      .LINE_BYTES (LINE_BYTES),
      .MEM_BYTES  (MEM_BYTES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_tuser),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_hit          (rsp_tuser),
      .rsp_read_data    (rsp_read_data),
      .rsp_miss_count   (rsp_miss_count),
      .rsp_access_count (rsp_access_count),
      .rsp_elapsed_time (rsp_elapsed_time)
   );

endmodule
